@@ sv/dtte_pkg.sv @@
package dtte_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned VALUE_W   = 49;
    localparam int unsigned STR_LEN   = 10;
    localparam int unsigned CNT_W     = 4;

    localparam logic [CHAR_W-1:0] CHAR_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;

    localparam logic [CNT_W-1:0] CNT_LAST_KEPT = 4'd9;
    localparam logic [CNT_W-1:0] CNT_FULL      = 4'd10;
    localparam logic [CNT_W-1:0] CNT_OVER      = 4'd11;

    // Julian day offset plus the 2000-01-01 epoch
    localparam logic signed [24:0] JDN_OFFSET = 25'sd2483590;
    localparam logic signed [24:0] DAYS_PER_YEAR = 25'sd365;
    // floor(y / 100) == (y * 5243) >> 19 for 0 <= y <= 10006
    localparam logic [12:0] RECIP100 = 13'd5243;
    localparam int unsigned RECIP100_SHIFT = 19;
    localparam logic signed [27:0] MS_PER_DAY = 28'sd86400000;

    typedef struct packed {
        logic accept;
        logic parse;
        logic calc1;
        logic calc2;
        logic calc3;
        logic load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_ctrl_stat;

    // (14 - month) / 12 with truncation, month in 0..99
    function automatic logic signed [3:0] month_adj(input logic [6:0] month);
        logic signed [3:0] adj;
        if (month <= 7'd2) begin
            adj = 4'sd1;
        end else if (month < 7'd26) begin
            adj = 4'sd0;
        end else if (month < 7'd38) begin
            adj = -4'sd1;
        end else if (month < 7'd50) begin
            adj = -4'sd2;
        end else if (month < 7'd62) begin
            adj = -4'sd3;
        end else if (month < 7'd74) begin
            adj = -4'sd4;
        end else if (month < 7'd86) begin
            adj = -4'sd5;
        end else if (month < 7'd98) begin
            adj = -4'sd6;
        end else begin
            adj = -4'sd7;
        end
        return adj;
    endfunction

    // (153 * m + 2) / 5 for shifted month m in 0..22
    function automatic logic [9:0] month_days(input logic [4:0] m);
        logic [9:0] d;
        case (m)
            5'd0:    d = 10'd0;
            5'd1:    d = 10'd31;
            5'd2:    d = 10'd61;
            5'd3:    d = 10'd92;
            5'd4:    d = 10'd122;
            5'd5:    d = 10'd153;
            5'd6:    d = 10'd184;
            5'd7:    d = 10'd214;
            5'd8:    d = 10'd245;
            5'd9:    d = 10'd275;
            5'd10:   d = 10'd306;
            5'd11:   d = 10'd337;
            5'd12:   d = 10'd367;
            5'd13:   d = 10'd398;
            5'd14:   d = 10'd428;
            5'd15:   d = 10'd459;
            5'd16:   d = 10'd490;
            5'd17:   d = 10'd520;
            5'd18:   d = 10'd551;
            5'd19:   d = 10'd581;
            5'd20:   d = 10'd612;
            5'd21:   d = 10'd643;
            5'd22:   d = 10'd673;
            default: d = 10'd0;
        endcase
        return d;
    endfunction

endpackage

@@ sv/dtte_in_if.sv @@
interface dtte_in_if;
    logic                              valid;
    logic                              ready;
    logic [dtte_pkg::CHAR_W-1:0]       char_code;
    logic                              last_char;

    modport source(output valid, output char_code, output last_char, input ready);
    modport sink(input valid, input char_code, input last_char, output ready);
endinterface

@@ sv/dtte_out_if.sv @@
interface dtte_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [dtte_pkg::VALUE_W-1:0] date_value;
    logic                               valid_res;

    modport source(output valid, output date_value, output valid_res, input ready);
    modport sink(input valid, input date_value, input valid_res, output ready);
endinterface

@@ sv/dtte_ctrl.sv @@
module dtte_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_last,
    output logic                  o_in_ready,
    input  dtte_pkg::t_ctrl_stat  i_stat,
    output dtte_pkg::t_ctrl_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_COLLECT,
        S_PARSE,
        S_CALC1,
        S_CALC2,
        S_CALC3,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_COLLECT);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = w_accept;
        n_state      = r_state;
        unique case (r_state)
            S_COLLECT: begin
                if (w_accept && i_in_last) begin
                    n_state = S_PARSE;
                end
            end
            S_PARSE: begin
                o_cmd.parse = 1'b1;
                n_state     = S_CALC1;
            end
            S_CALC1: begin
                o_cmd.calc1 = 1'b1;
                n_state     = S_CALC2;
            end
            S_CALC2: begin
                o_cmd.calc2 = 1'b1;
                n_state     = S_CALC3;
            end
            S_CALC3: begin
                o_cmd.calc3 = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                // hold until the output register can take the word
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/dtte_dp.sv @@
module dtte_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dtte_pkg::t_ctrl_cmd                  i_cmd,
    output dtte_pkg::t_ctrl_stat                 o_stat,
    input  logic [dtte_pkg::CHAR_W-1:0]          i_char_code,
    input  logic                                 i_last_char,
    input  logic                                 i_cfg_wr_en,
    input  logic                                 i_cfg_wr_data,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [dtte_pkg::VALUE_W-1:0]  o_date_value,
    output logic                                 o_valid_res
);

    logic [dtte_pkg::CHAR_W-1:0] r_store [dtte_pkg::STR_LEN];
    logic [dtte_pkg::CNT_W-1:0]  r_count;
    logic                        r_len_ok;
    logic                        r_ms;

    logic [13:0]        r_year;
    logic [6:0]         r_month;
    logic [6:0]         r_day;
    logic               r_ok;
    logic signed [14:0] r_y;
    logic [4:0]         r_m;
    logic [6:0]         r_day1;
    logic signed [24:0] r_base;
    logic [11:0]        r_q4;
    logic [6:0]         r_q100;
    logic signed [24:0] r_days;
    logic               r_out_valid;
    logic signed [dtte_pkg::VALUE_W-1:0] r_out_value;
    logic               r_out_res;

    // character store and length count
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (r_count < dtte_pkg::CNT_FULL)) begin
            r_store[r_count] <= i_char_code;
        end
        if (i_cmd.accept && i_last_char) begin
            r_len_ok <= (r_count == dtte_pkg::CNT_LAST_KEPT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ms    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ms <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                if (i_last_char) begin
                    r_count <= '0;
                end else if (r_count < dtte_pkg::CNT_OVER) begin
                    r_count <= r_count + 4'd1;
                end
            end
        end
    end

    // parse: digit check and field values
    logic [3:0] w_dig [dtte_pkg::STR_LEN];
    logic [dtte_pkg::STR_LEN-1:0] w_isdig;
    logic       w_ymd;
    logic       w_mdy;
    logic [13:0] w_year;
    logic [6:0]  w_month;
    logic [6:0]  w_day;
    logic        w_digits_ok;

    always_comb begin
        for (int i = 0; i < dtte_pkg::STR_LEN; i++) begin
            w_isdig[i] = (r_store[i] >= dtte_pkg::CHAR_0) && (r_store[i] <= dtte_pkg::CHAR_9);
            w_dig[i]   = 4'(r_store[i] - dtte_pkg::CHAR_0);
        end
    end

    function automatic logic [6:0] num2(input logic [3:0] d1, input logic [3:0] d0);
        return 7'(d1) * 7'd10 + 7'(d0);
    endfunction

    function automatic logic [13:0] num4(input logic [3:0] d3, input logic [3:0] d2,
                                         input logic [3:0] d1, input logic [3:0] d0);
        return 14'(d3) * 14'd1000 + 14'(d2) * 14'd100 + 14'(d1) * 14'd10 + 14'(d0);
    endfunction

    always_comb begin
        w_ymd = (r_store[4] == dtte_pkg::CHAR_DASH);
        w_mdy = !w_ymd && (r_store[2] == dtte_pkg::CHAR_DASH);
        if (w_ymd) begin
            w_year      = num4(w_dig[0], w_dig[1], w_dig[2], w_dig[3]);
            w_month     = num2(w_dig[5], w_dig[6]);
            w_day       = num2(w_dig[8], w_dig[9]);
            w_digits_ok = &{w_isdig[3:0], w_isdig[6:5], w_isdig[9:8]};
        end else begin
            w_month     = num2(w_dig[0], w_dig[1]);
            w_day       = num2(w_dig[3], w_dig[4]);
            w_year      = num4(w_dig[6], w_dig[7], w_dig[8], w_dig[9]);
            w_digits_ok = &{w_isdig[1:0], w_isdig[4:3], w_isdig[9:6]};
        end
    end

    // calc1: shift the year so that it starts in March
    logic signed [3:0]  w_a;
    logic signed [8:0]  w_a9;
    logic signed [8:0]  w_m_full;
    logic signed [14:0] w_y;

    assign w_a      = dtte_pkg::month_adj(r_month);
    assign w_a9     = {{5{w_a[3]}}, w_a};
    assign w_m_full = $signed({2'b00, r_month}) + w_a9 * 9'sd12 - 9'sd3;
    assign w_y      = $signed({1'b0, r_year}) - $signed({{11{w_a[3]}}, w_a});

    // calc2: leap-year quotients; y is never below -1, where all of them are zero
    logic [13:0] w_ypos;
    logic [26:0] w_prod;
    logic signed [24:0] w_y25;

    assign w_ypos = r_y[14] ? 14'd0 : r_y[13:0];
    assign w_prod = 27'(w_ypos) * 27'(dtte_pkg::RECIP100);
    assign w_y25  = {{10{r_y[14]}}, r_y};

    // load: optional scaling to milliseconds
    logic signed [52:0] w_ms;
    logic signed [dtte_pkg::VALUE_W-1:0] w_days49;

    assign w_ms     = r_days * dtte_pkg::MS_PER_DAY;
    assign w_days49 = {{(dtte_pkg::VALUE_W-25){r_days[24]}}, r_days};

    always_ff @(posedge i_clk) begin
        if (i_cmd.parse) begin
            r_year  <= w_year;
            r_month <= w_month;
            r_day   <= w_day;
            r_ok    <= r_len_ok && (w_ymd || w_mdy) && w_digits_ok;
        end
        if (i_cmd.calc1) begin
            r_y    <= w_y;
            r_m    <= w_m_full[4:0];
            r_day1 <= r_day;
        end
        if (i_cmd.calc2) begin
            r_q4   <= w_ypos[13:2];
            r_q100 <= w_prod[dtte_pkg::RECIP100_SHIFT +: 7];
            r_base <= $signed({18'd0, r_day1})
                    + $signed({15'd0, dtte_pkg::month_days(r_m)})
                    + w_y25 * dtte_pkg::DAYS_PER_YEAR
                    - dtte_pkg::JDN_OFFSET;
        end
        if (i_cmd.calc3) begin
            r_days <= r_base + $signed({13'd0, r_q4}) - $signed({18'd0, r_q100})
                    + $signed({20'd0, r_q100[6:2]});
        end
        if (i_cmd.load) begin
            r_out_res <= r_ok;
            if (!r_ok) begin
                r_out_value <= '0;
            end else if (r_ms) begin
                r_out_value <= w_ms[dtte_pkg::VALUE_W-1:0];
            end else begin
                r_out_value <= w_days49;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_date_value    = r_out_value;
    assign o_valid_res     = r_out_res;

endmodule

@@ sv/date_text_to_epoch_days_top.sv @@
// Date text to day count since 2000-01-01.
// Input channel i_in_ch: one ASCII character per word, last_char marks the end
// of a string. Output channel o_out_ch: one word per string, date_value (days,
// or milliseconds when the configuration bit is set) and valid_res.
// Ten-character strings in YYYY-MM-DD or MM-DD-YYYY form, with any byte as the
// second separator, are converted; others give date_value 0, valid_res low.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the millisecond mode bit.
// Throughput: characters are taken one per cycle while collecting. After the
// last character the input stalls while the controller steps the datapath
// through parse, three arithmetic steps and the output load; the result word
// is valid once the load step has written it into the output register.
// The result sits in an output register; while the receiver stalls it holds
// there and the next string is collected, and only the load step waits for
// the register to free up.
// Reset (synchronous, active low) clears the character count, the mode bit,
// the controller state and the output valid.
module date_text_to_epoch_days_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    dtte_in_if.sink     i_in_ch,
    dtte_out_if.source  o_out_ch
);

    dtte_pkg::t_ctrl_cmd  w_cmd;
    dtte_pkg::t_ctrl_stat w_stat;

    dtte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_in_last  (i_in_ch.last_char),
        .o_in_ready (i_in_ch.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    dtte_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_char_code   (i_in_ch.char_code),
        .i_last_char   (i_in_ch.last_char),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (o_out_ch.ready),
        .o_out_valid   (o_out_ch.valid),
        .o_date_value  (o_out_ch.date_value),
        .o_valid_res   (o_out_ch.valid_res)
    );

endmodule

@@ sv/dtte_chk.sv @@
module dtte_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic                                 i_in_last,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic signed [dtte_pkg::VALUE_W-1:0]  i_out_value,
    input logic                                 i_out_res
);

    // a stalled word stays on the port
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_value) && $stable(i_out_res))
        else $error("output word changed while stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_res |-> i_out_value == '0)
        else $error("invalid result carries a nonzero value");

    // the end of a string starts the conversion, which blocks the input
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready ##1 !i_in_ready)
        else $error("input taken during conversion");

endmodule

bind date_text_to_epoch_days_top dtte_chk u_dtte_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_in_last   (i_in_ch.last_char),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_value (o_out_ch.date_value),
    .i_out_res   (o_out_ch.valid_res)
);

@@ tb/sv/tb_date_text_to_epoch_days_top.sv @@
`timescale 1ns / 1ps

module tb_date_text_to_epoch_days_top;

    localparam int  PHASE_CHARS    = 312;
    localparam int  SETTLE_CYCLES  = 16;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam longint EPOCH_JDN   = 2451545;
    localparam longint JDN_BASE    = 32045;

    typedef struct {
        logic [dtte_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_char_word;

    typedef struct {
        logic signed [dtte_pkg::VALUE_W-1:0] value;
        logic                                ok;
    } t_date_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    dtte_in_if  in_ch();
    dtte_out_if out_ch();

    date_text_to_epoch_days_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_ch       (in_ch),
        .o_out_ch      (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_char_word                  pending_chars[$];
    logic [dtte_pkg::CHAR_W-1:0] text_buf[$];
    t_date_result                expected_dates[$];

    // mirror of the block's state
    logic [dtte_pkg::CHAR_W-1:0] text_bytes[dtte_pkg::STR_LEN];
    logic [dtte_pkg::CNT_W-1:0]  text_len = '0;
    logic                        ms_mode = 1'b0;

    logic in_taken = 1'b0;
    logic calm = 1'b0;
    int   src_gap = 0;
    int   sink_stall = 0;
    int   idle_count = 0;
    int   mismatch_count = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic read_number(input int first, input int len, output longint v);
        logic                        ok;
        logic [dtte_pkg::CHAR_W-1:0] c;
        ok = 1'b1;
        v = 0;
        for (int i = 0; i < len; i++) begin
            c = text_bytes[first + i];
            if (c < dtte_pkg::CHAR_0 || c > dtte_pkg::CHAR_9)
                ok = 1'b0;
            else
                v = v * 10 + longint'(c - dtte_pkg::CHAR_0);
        end
        return ok;
    endfunction

    function automatic logic text_to_days(output longint days);
        longint year, month, day, a, y, m, jdn;
        logic   ok;
        days = 0;
        if (text_len != dtte_pkg::CNT_FULL)
            return 1'b0;
        if (text_bytes[4] == dtte_pkg::CHAR_DASH) begin
            ok = read_number(0, 4, year);
            ok = ok & read_number(5, 2, month);
            ok = ok & read_number(8, 2, day);
        end else if (text_bytes[2] == dtte_pkg::CHAR_DASH) begin
            ok = read_number(0, 2, month);
            ok = ok & read_number(3, 2, day);
            ok = ok & read_number(6, 4, year);
        end else begin
            return 1'b0;
        end
        if (!ok)
            return 1'b0;
        // signed division truncates toward zero, as the formula expects
        a = (14 - month) / 12;
        y = year - a;
        m = month + 12 * a - 3;
        jdn = day + (153 * m + 2) / 5 + 365 * y + y / 4 - y / 100 + y / 400 - JDN_BASE;
        days = jdn - EPOCH_JDN;
        return 1'b1;
    endfunction

    function automatic void predict_char(input logic [dtte_pkg::CHAR_W-1:0] code,
                                         input logic last);
        t_date_result res;
        longint       days;
        if (text_len < dtte_pkg::CNT_FULL)
            text_bytes[text_len] = code;
        if (text_len < dtte_pkg::CNT_OVER)
            text_len = text_len + 1'b1;
        if (!last)
            return;
        res.ok = text_to_days(days);
        text_len = '0;
        if (!res.ok)
            days = 0;
        else if (ms_mode)
            days = days * dtte_pkg::MS_PER_DAY;
        res.value = days[dtte_pkg::VALUE_W-1:0];
        expected_dates.push_back(res);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endfunction

    // move the scratch string into the send queue, flag on its final byte
    function automatic int flush_text();
        t_char_word w;
        int         n;
        n = text_buf.size();
        for (int i = 0; i < n; i++) begin
            w.code = text_buf[i];
            w.last = (i == n - 1);
            pending_chars.push_back(w);
        end
        text_buf.delete();
        return n;
    endfunction

    function automatic void build_random_text();
        int  year, month, day, r, n;
        logic iso;
        iso = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 7);
        year = (r == 0) ? 0 : (r == 1) ? 9999 : $urandom_range(0, 9999);
        month = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
        day = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
        text_buf.delete();
        if (iso)
            put_text($sformatf("%04d-%02d-%02d", year, month, day));
        else
            put_text($sformatf("%02d-%02d-%04d", month, day, year));
        // the second separator is not checked
        if ($urandom_range(0, 3) == 0)
            text_buf[iso ? 7 : 5] = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 70) begin
        end else if (r < 80) begin
            text_buf[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
        end else if (r < 87) begin
            n = $urandom_range(1, 9);
            while (text_buf.size() > n)
                void'(text_buf.pop_back());
        end else if (r < 93) begin
            n = $urandom_range(1, 4);
            repeat (n)
                text_buf.push_back($urandom_range(0, 1)
                                   ? 8'($urandom_range(dtte_pkg::CHAR_0, dtte_pkg::CHAR_9))
                                   : 8'($urandom_range(0, 255)));
        end else begin
            text_buf.delete();
            n = $urandom_range(1, 14);
            repeat (n)
                text_buf.push_back(8'($urandom_range(0, 255)));
            if (n > 4 && $urandom_range(0, 1))
                text_buf[$urandom_range(0, 1) ? 4 : 2] = dtte_pkg::CHAR_DASH;
        end
    endfunction

    task automatic set_ms_mode(input logic v);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = v;
        ms_mode = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // drain everything, then let the datapath settle
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_chars.size() != 0 || in_ch.valid || expected_dates.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // character source
    always @(negedge i_clk) begin : char_source
        t_char_word w;
        logic       next_valid;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!(in_ch.valid && !in_taken)) begin
            next_valid = 1'b0;
            if (src_gap != 0) begin
                src_gap = src_gap - 1;
            end else if (pending_chars.size() != 0) begin
                w = pending_chars.pop_front();
                in_ch.char_code <= w.code;
                in_ch.last_char <= w.last;
                next_valid = 1'b1;
                src_gap = pick_gap();
            end
            in_ch.valid <= next_valid;
        end
    end

    // result sink stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (sink_stall != 0) begin
            out_ch.ready <= 1'b0;
            sink_stall = sink_stall - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_stall = pick_gap();
        end
    end

    always @(posedge i_clk) begin : monitor
        t_date_result want;
        logic         in_fire;
        logic         out_fire;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            idle_count = 0;
        end else begin
            in_fire = in_ch.valid && in_ch.ready;
            out_fire = out_ch.valid && out_ch.ready;
            in_taken <= in_fire;
            if (out_fire) begin
                if (expected_dates.size() == 0) begin
                    $error("result word with nothing pending: date_value=%0d valid_res=%0b",
                           out_ch.date_value, out_ch.valid_res);
                    mismatch_count++;
                end else begin
                    want = expected_dates.pop_front();
                    if (out_ch.date_value !== want.value) begin
                        $error("date_value: expected %0d, actual %0d",
                               want.value, out_ch.date_value);
                        mismatch_count++;
                    end
                    if (out_ch.valid_res !== want.ok) begin
                        $error("valid_res: expected %0b, actual %0b",
                               want.ok, out_ch.valid_res);
                        mismatch_count++;
                    end
                end
            end
            if (in_fire) begin
                predict_char(in_ch.char_code, in_ch.last_char);
                if ($urandom_range(0, 79) == 0)
                    calm <= !calm;
            end
            if (in_fire || out_fire)
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("date_text_to_epoch_days_top test failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int sent;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.char_code = '0;
        in_ch.last_char = 1'b0;
        out_ch.ready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        set_ms_mode(1'b0);
        // largest ISO fields, smallest US fields, a lone high byte
        put_text("9999-99-99");
        void'(flush_text());
        put_text("00-00-0000");
        void'(flush_text());
        text_buf.push_back(8'hFF);
        void'(flush_text());
        wait_idle();

        for (int phase = 1; phase <= 4; phase++) begin
            set_ms_mode(phase[0]);
            sent = 0;
            while (sent < PHASE_CHARS) begin
                build_random_text();
                sent += flush_text();
            end
            wait_idle();
        end

        if (expected_dates.size() != 0) begin
            $error("%0d result words never arrived", expected_dates.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("date_text_to_epoch_days_top test passed");
        else
            $display("date_text_to_epoch_days_top test failed");
        $finish;
    end

endmodule
